// ===== rtl/core/egd_pkg.sv =====
// Package for the egg-drop minimum-trials engine.
// Holds sizes, the sequencer state type and shared constants; no dependencies.
package egd_pkg;

    localparam int BALL_W    = 5;
    localparam int FLOOR_W   = 8;
    localparam int ROW_DEPTH = 1 << FLOOR_W;
    localparam int MIN_W     = FLOOR_W + 1;

    localparam logic [BALL_W-1:0] MAX_BALLS = 5'd16;
    localparam logic [MIN_W-1:0]  MIN_INIT  = {MIN_W{1'b1}};

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_FILL       = 7'b0000010,
        ST_TRIAL      = 7'b0000100,
        ST_WRITE      = 7'b0001000,
        ST_FINAL_RD   = 7'b0010000,
        ST_FINAL_WAIT = 7'b0100000,
        ST_DONE       = 7'b1000000
    } egd_state_t;

endpackage

// ===== rtl/core/egd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module egd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/egg_drop_min_trials_dp_unit.sv =====
// Egg-drop minimum-trials engine: one shared compare/min unit under a sequencer.
// Zero balls skip the table and go straight to the result state.
// One query at a time; the inner trial loop (one RAM read pair per cycle) dominates run time.
// Reset (rst_n, async, active low) clears control state; row RAMs are not cleared.
// Uses egd_pkg and egd_ram (two instances, ping-ponged as previous/current row).
module egg_drop_min_trials_dp_unit
    import egd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] balls, [12:5] floors, [15:13] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [7:0] drops
);

    egd_state_t state_reg, state_next;

    logic [BALL_W-1:0]  nb_reg, nb_next;
    logic [BALL_W-1:0]  b_reg, b_next;
    logic [FLOOR_W-1:0] nfl_reg, nfl_next;
    logic [FLOOR_W-1:0] j_reg, j_next;
    logic [FLOOR_W-1:0] x_reg, x_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               sel_reg, sel_next;
    logic [FLOOR_W-1:0] res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [FLOOR_W-1:0] m_data_reg, m_data_next;

    logic [BALL_W-1:0]  in_balls;
    logic [FLOOR_W-1:0] in_floors;
    logic               s_fire;

    logic               ram_we;
    logic [FLOOR_W-1:0] ram_waddr;
    logic [FLOOR_W-1:0] ram_wdata;
    logic [FLOOR_W-1:0] prev_raddr;
    logic [FLOOR_W-1:0] cur_raddr;
    logic [FLOOR_W-1:0] rd0, rd1;
    logic [FLOOR_W-1:0] prev_rdata, cur_rdata;
    logic [FLOOR_W-1:0] worst_max;
    logic [MIN_W-1:0]   worst;
    logic [MIN_W-1:0]   min_comb;
    logic [FLOOR_W-1:0] fill_end;
    logic               row_last;

    assign in_balls  = s_tdata[BALL_W-1:0];
    assign in_floors = s_tdata[BALL_W+FLOOR_W-1:BALL_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;

    // Row buffers swap roles each ball count instead of copying
    assign prev_rdata = sel_reg ? rd0 : rd1;
    assign cur_rdata  = sel_reg ? rd1 : rd0;

    egd_ram #(.WIDTH(FLOOR_W), .DEPTH(ROW_DEPTH)) u_row0 (
        .clk   (clk),
        .we    (ram_we && !sel_reg),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (sel_reg ? prev_raddr : cur_raddr),
        .rdata (rd0)
    );

    egd_ram #(.WIDTH(FLOOR_W), .DEPTH(ROW_DEPTH)) u_row1 (
        .clk   (clk),
        .we    (ram_we && sel_reg),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (sel_reg ? cur_raddr : prev_raddr),
        .rdata (rd1)
    );

    // Shared trial unit: 1 + max(broke, held), folded into the running minimum
    assign worst_max = (prev_rdata > cur_rdata) ? prev_rdata : cur_rdata;
    assign worst     = {1'b0, worst_max} + {{(MIN_W-1){1'b0}}, 1'b1};
    assign min_comb  = (rd_valid_reg && (worst < min_reg)) ? worst : min_reg;

    // Row one fills every floor; later rows only seed floors 0 and 1
    assign fill_end = (b_reg == {{(BALL_W-1){1'b0}}, 1'b1}) ? nfl_reg :
                      ((nfl_reg == '0) ? '0 : {{(FLOOR_W-1){1'b0}}, 1'b1});
    assign row_last = (b_reg == nb_reg);

    always_comb
    begin
        state_next    = state_reg;
        nb_next       = nb_reg;
        b_next        = b_reg;
        nfl_next      = nfl_reg;
        j_next        = j_reg;
        x_next        = x_reg;
        min_next      = min_reg;
        sel_next      = sel_reg;
        res_next      = res_reg;
        rd_valid_next = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = j_reg;
        ram_wdata     = j_reg;
        prev_raddr    = x_reg - {{(FLOOR_W-1){1'b0}}, 1'b1};
        cur_raddr     = j_reg - x_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    nb_next  = (in_balls > MAX_BALLS) ? MAX_BALLS : in_balls;
                    nfl_next = in_floors;
                    b_next   = {{(BALL_W-1){1'b0}}, 1'b1};
                    j_next   = '0;
                    sel_next = 1'b0;
                    min_next = MIN_INIT;
                    if (in_balls == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (j_reg == fill_end)
                begin
                    if ((b_reg != {{(BALL_W-1){1'b0}}, 1'b1}) &&
                        (nfl_reg > {{(FLOOR_W-1){1'b0}}, 1'b1}))
                    begin
                        j_next     = {{(FLOOR_W-2){1'b0}}, 2'd2};
                        x_next     = {{(FLOOR_W-1){1'b0}}, 1'b1};
                        state_next = ST_TRIAL;
                    end
                    else if (row_last)
                    begin
                        state_next = ST_FINAL_RD;
                    end
                    else
                    begin
                        b_next     = b_reg + {{(BALL_W-1){1'b0}}, 1'b1};
                        sel_next   = !sel_reg;
                        j_next     = '0;
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    j_next = j_reg + {{(FLOOR_W-1){1'b0}}, 1'b1};
                end
            end
            ST_TRIAL:
            begin
                rd_valid_next = 1'b1;
                min_next      = min_comb;
                if (x_reg == j_reg)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    x_next = x_reg + {{(FLOOR_W-1){1'b0}}, 1'b1};
                end
            end
            ST_WRITE:
            begin
                // last read pair lands here and is folded in before the write
                ram_we    = 1'b1;
                ram_wdata = min_comb[FLOOR_W-1:0];
                min_next  = MIN_INIT;
                if (j_reg != nfl_reg)
                begin
                    j_next     = j_reg + {{(FLOOR_W-1){1'b0}}, 1'b1};
                    x_next     = {{(FLOOR_W-1){1'b0}}, 1'b1};
                    state_next = ST_TRIAL;
                end
                else if (row_last)
                begin
                    state_next = ST_FINAL_RD;
                end
                else
                begin
                    b_next     = b_reg + {{(BALL_W-1){1'b0}}, 1'b1};
                    sel_next   = !sel_reg;
                    j_next     = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FINAL_RD:
            begin
                cur_raddr  = nfl_reg;
                state_next = ST_FINAL_WAIT;
            end
            ST_FINAL_WAIT:
            begin
                res_next   = cur_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            nb_reg       <= '0;
            b_reg        <= '0;
            nfl_reg      <= '0;
            j_reg        <= '0;
            x_reg        <= '0;
            min_reg      <= MIN_INIT;
            rd_valid_reg <= 1'b0;
            sel_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            nb_reg       <= nb_next;
            b_reg        <= b_next;
            nfl_reg      <= nfl_next;
            j_reg        <= j_next;
            x_reg        <= x_next;
            min_reg      <= min_next;
            rd_valid_reg <= rd_valid_next;
            sel_reg      <= sel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Row buffers are written only while filling or storing a trial minimum
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_FILL || state_reg == ST_WRITE))
        else $error("row write outside fill or store");

    // Trial position stays within 1..j
    a_trial_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIAL) |-> (x_reg != '0 && x_reg <= j_reg))
        else $error("trial index out of range");

    // A stored entry never exceeds its floor number
    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (min_comb <= {1'b0, j_reg}))
        else $error("table entry above floor count");

    // Zero balls skip the table entirely
    a_zero_balls: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_balls == '0) |=> (state_reg == ST_DONE && res_reg == '0))
        else $error("zero-ball query not answered directly");

endmodule

// ===== test/tb.sv =====
// Testbench for egg_drop_min_trials_dp_unit: queues ball/floor queries, predicts min drops
// with its own two-row table rebuild, and checks each result transfer in order.
// Depends on egd_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
    import egd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int IDLE_PERCENT   = 34;

    typedef struct packed {
        logic [BALL_W-1:0]  balls;
        logic [FLOOR_W-1:0] floors;
    } drop_query_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;     // [4:0] balls, [12:5] floors, [15:13] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [7:0] drops

    drop_query_t          queries_to_send[$];
    logic [M_TDATA_W-1:0] drops_awaited[$];
    int                   queries_sent = 0;
    int                   mismatches = 0;
    int                   quiet_cycles = 0;
    logic                 calm;

    egg_drop_min_trials_dp_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // no idling on either side while this window of queries goes through
    assign calm = (queries_sent >= 40) && (queries_sent < 70);

    // Worst-case drops: row for b balls built from row for b-1, floor by floor.
    function automatic logic [M_TDATA_W-1:0] worst_case_drops(logic [BALL_W-1:0] balls_in,
                                                              logic [FLOOR_W-1:0] floors_in);
        int lower_row[ROW_DEPTH];
        int upper_row[ROW_DEPTH];
        int nb;
        int nfl;
        int best;
        int worst;
        nb  = (balls_in > MAX_BALLS) ? int'(MAX_BALLS) : int'(balls_in);
        nfl = int'(floors_in);
        if (nb == 0)
            return '0;
        for (int j = 0; j <= nfl; j++)
            upper_row[j] = j;
        for (int b = 2; b <= nb; b++)
        begin
            lower_row = upper_row;
            upper_row[0] = 0;
            if (nfl >= 1)
                upper_row[1] = 1;
            for (int j = 2; j <= nfl; j++)
            begin
                best = int'(MIN_INIT);
                for (int x = 1; x <= j; x++)
                begin
                    worst = 1 + ((lower_row[x-1] > upper_row[j-x]) ? lower_row[x-1]
                                                                   : upper_row[j-x]);
                    if (worst < best)
                        best = worst;
                end
                upper_row[j] = best;
            end
        end
        return (upper_row[nfl] > 255) ? 8'd255 : M_TDATA_W'(upper_row[nfl]);
    endfunction

    task automatic add_query(int balls, int floors);
        drop_query_t q;
        q.balls  = BALL_W'(balls);
        q.floors = FLOOR_W'(floors);
        queries_to_send.push_back(q);
    endtask

    // Driver: next query is presented once the previous transfer has completed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                drops_awaited.push_back(worst_case_drops(s_tdata[BALL_W-1:0],
                                                         s_tdata[BALL_W+FLOOR_W-1:BALL_W]));
                queries_sent <= queries_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (queries_to_send.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    drop_query_t q;
                    q = queries_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-BALL_W-FLOOR_W){1'b0}}, q.floors, q.balls};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Monitor: every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drops_awaited.size() == 0)
            begin
                $error("drops: no result expected, got %0d", m_tdata);
                mismatches <= mismatches + 1;
            end
            else
            begin
                logic [M_TDATA_W-1:0] want;
                want = drops_awaited.pop_front();
                if (m_tdata !== want)
                begin
                    $error("drops: expected %0d, got %0d", want, m_tdata);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int pick;
        // directed: field extremes, zero balls, zero floors, clamped ball counts
        add_query(0, 0);
        add_query(0, 255);
        add_query(1, 0);
        add_query(1, 1);
        add_query(1, 255);
        add_query(2, 0);
        add_query(2, 1);
        add_query(2, 2);
        add_query(2, 100);
        add_query(2, 255);
        add_query(3, 36);
        add_query(16, 0);
        add_query(16, 1);
        add_query(16, 2);
        add_query(16, 40);
        add_query(17, 10);
        add_query(31, 20);
        add_query(31, 0);
        add_query(8, 64);
        add_query(5, 128);
        add_query(31, 255);     // clamps to the largest table: the longest query
        // random: mostly small tables, a few wide floor counts with few balls
        for (int i = 0; i < 80; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                add_query($urandom_range(2), $urandom_range(255, 128));
            else if (pick < 24)
                add_query($urandom_range(4), $urandom_range(47, 16));
            else
                add_query($urandom_range(31), $urandom_range(15));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (queries_to_send.size() != 0 || s_tvalid)
            @(posedge clk);
        while (drops_awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/egd_pkg.sv
rtl/core/egd_ram.sv
rtl/core/egg_drop_min_trials_dp_unit.sv
test/tb.sv
